>>> rtl/core/swm_pkg.sv
// Package for the sliding window median core: shared types and constants.
// No dependencies; imported by swm_cell and sliding_window_median_core.
package swm_pkg;

  localparam int SAMPLE_W = 32;
  localparam int WSIZE_W  = 7;
  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;

  // register indexes (paddr[2])
  localparam logic REG_WINDOW_SIZE = 1'b0;

  // word handed between neighboring cells
  typedef struct packed {
    logic                       mv_up;  // value moves one slot toward the top
    logic                       mv_dn;  // value moves one slot toward the bottom
    logic signed [SAMPLE_W-1:0] val;
  } swm_link_t;

endpackage

>>> rtl/core/swm_cell.sv
// One slot of the sorted window: holds a value and its age, trades with neighbors.
// Depends on swm_pkg.
module swm_cell #(
  parameter int AGE_W = 6
) (
  input  logic                               clk,
  input  logic                               upd,
  input  logic                               occ,
  input  logic                               full,
  input  logic [AGE_W-1:0]                   size_m1,
  input  logic signed [swm_pkg::SAMPLE_W-1:0] key,
  input  logic signed [swm_pkg::SAMPLE_W-1:0] rv,
  input  swm_pkg::swm_link_t                 from_lo,
  input  logic [AGE_W-1:0]                   age_lo,
  input  swm_pkg::swm_link_t                 from_hi,
  input  logic [AGE_W-1:0]                   age_hi,
  output swm_pkg::swm_link_t                 link,
  output logic [AGE_W-1:0]                   age,
  output logic                               rm
);
  import swm_pkg::*;

  logic signed [SAMPLE_W-1:0] val;
  logic signed [SAMPLE_W-1:0] val_next;
  logic [AGE_W-1:0]           age_next;
  logic                       gt;
  logic                       above_rm;
  logic                       stay;

  // oldest entry is the first of its equal-value group, so index order
  // relative to the removed slot is decided locally
  always_comb begin
    gt       = occ && (val > key);
    rm       = full && occ && (age == size_m1);
    above_rm = full && occ && !rm && (val >= rv);
    stay     = occ && !rm && (above_rm == gt);
    link.mv_up = occ && gt && !above_rm;
    link.mv_dn = occ && above_rm && !gt;
    link.val   = val;
  end

  always_comb begin
    if (stay) begin
      val_next = val;
      age_next = age + 1'b1;
    end else if (from_hi.mv_dn) begin
      val_next = from_hi.val;
      age_next = age_hi + 1'b1;
    end else if (from_lo.mv_up) begin
      val_next = from_lo.val;
      age_next = age_lo + 1'b1;
    end else begin
      val_next = key;
      age_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      val <= val_next;
      age <= age_next;
    end
  end

endmodule

>>> rtl/core/sliding_window_median_core.sv
// Top level of the sliding window median core: cell row, fill control,
// output stage and APB register. Depends on swm_pkg and swm_cell.
//
// Usage:
//   s_* channel takes one sample word per cycle while s_tready is high (tdata
//   = sample, tlast = end of sequence). m_* channel gives the lower median of
//   the window (tdata = median, tlast = end of sequence of the sample that
//   caused it). Samples taken while the window is still filling give nothing;
//   the sample that fills the window and every later one give one word.
// Output path: a result waits in the pending stage, then the output register.
// Throughput: one sample per cycle while s_tready is high; all WINDOW_MAX
//   cells insert and remove in parallel, each trading with its neighbors.
// Stall: a pending result waits in a stage ahead of the output register, so
//   one more sample is taken while m_tready is low; s_tready then drops until
//   the output drains.
// Reset: window emptied, window_size = 1, no pending results. No clearing
//   pass is needed. Writing window_size (APB, byte address 0) empties the
//   window; write it only while the core is idle.
module sliding_window_median_core #(
  parameter int WINDOW_MAX = 64
) (
  input  logic                               clk,
  input  logic                               rst,
  // APB register port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [swm_pkg::APB_AW-1:0]         paddr,
  input  logic [swm_pkg::APB_DW-1:0]         pwdata,
  output logic [swm_pkg::APB_DW-1:0]         prdata,
  output logic                               pready,
  // sample input
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic signed [swm_pkg::SAMPLE_W-1:0] s_tdata,  // [31:0] sample
  input  logic                               s_tlast,   // end of sequence
  // median output
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic signed [swm_pkg::SAMPLE_W-1:0] m_tdata,  // [31:0] median
  output logic                               m_tlast    // end of sequence out
);
  import swm_pkg::*;

  localparam int AGE_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CNT_W = $clog2(WINDOW_MAX + 1);

  logic [WSIZE_W-1:0] window_size;
  logic [CNT_W-1:0]   fill;
  logic [CNT_W-1:0]   fill_next;
  logic [CNT_W-1:0]   size_eff;
  logic [AGE_W-1:0]   size_m1;
  logic [AGE_W-1:0]   rank;
  logic               full;
  logic               fills;
  logic               accept;
  logic               cfg_wr;

  // pending result: cells already hold the window it reads
  logic               p_valid;
  logic               p_eos;
  logic               s2_free;

  swm_link_t                  links [WINDOW_MAX];
  logic [AGE_W-1:0]           ages  [WINDOW_MAX];
  logic [WINDOW_MAX-1:0]      rms;
  logic [WINDOW_MAX-1:0]      occ;
  logic signed [SAMPLE_W-1:0] rv;

  assign pready = 1'b1;
  assign prdata = {{(APB_DW-WSIZE_W){1'b0}}, window_size};
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_WINDOW_SIZE);

  // clamp: 0 acts as 1, above capacity acts as capacity
  always_comb begin
    if (window_size == '0)
      size_eff = CNT_W'(1);
    else if (int'(window_size) > WINDOW_MAX)
      size_eff = CNT_W'(WINDOW_MAX);
    else
      size_eff = CNT_W'(window_size);
  end

  assign size_m1 = AGE_W'(size_eff - 1'b1);
  assign rank    = size_m1 >> 1;
  assign full    = (fill >= size_eff);
  // window is full once this sample is in: the filling sample counts too
  assign fills   = full || ((fill + CNT_W'(1)) == size_eff);

  assign s2_free  = !m_tvalid || m_tready;
  assign s_tready = !p_valid || s2_free;
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    for (int i = 0; i < WINDOW_MAX; i++)
      occ[i] = (fill > CNT_W'(i));
  end

  // value of the outgoing (oldest) sample; exactly one cell flags it when full
  always_comb begin
    rv = '0;
    for (int i = 0; i < WINDOW_MAX; i++)
      rv = rv | (rms[i] ? links[i].val : '0);
  end

  for (genvar g = 0; g < WINDOW_MAX; g++) begin : g_cell
    swm_link_t        lo_link;
    swm_link_t        hi_link;
    logic [AGE_W-1:0] lo_age;
    logic [AGE_W-1:0] hi_age;

    if (g == 0) begin : g_lo_edge
      assign lo_link = '0;
      assign lo_age  = '0;
    end else begin : g_lo
      assign lo_link = links[g-1];
      assign lo_age  = ages[g-1];
    end

    if (g == WINDOW_MAX - 1) begin : g_hi_edge
      assign hi_link = '0;
      assign hi_age  = '0;
    end else begin : g_hi
      assign hi_link = links[g+1];
      assign hi_age  = ages[g+1];
    end

    swm_cell #(.AGE_W(AGE_W)) u_cell (
      .clk     (clk),
      .upd     (accept),
      .occ     (occ[g]),
      .full    (full),
      .size_m1 (size_m1),
      .key     (s_tdata),
      .rv      (rv),
      .from_lo (lo_link),
      .age_lo  (lo_age),
      .from_hi (hi_link),
      .age_hi  (hi_age),
      .link    (links[g]),
      .age     (ages[g]),
      .rm      (rms[g])
    );
  end

  always_comb begin
    if (s_tlast)
      fill_next = '0;
    else if (full)
      fill_next = fill;
    else
      fill_next = fill + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= WSIZE_W'(1);
      fill        <= '0;
    end else if (cfg_wr) begin
      window_size <= pwdata[WSIZE_W-1:0];
      fill        <= '0;
    end else if (accept) begin
      fill        <= fill_next;
    end
  end

  // pending stage
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (accept) begin
      p_valid <= fills;
    end else if (s2_free) begin
      p_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept)
      p_eos <= s_tlast;
  end

  // output register: picks the lower median from the cell row
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (p_valid && s2_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (p_valid && s2_free) begin
      m_tdata <= links[rank].val;
      m_tlast <= p_eos;
    end
  end

endmodule

>>> sim/tb_sliding_window_median_core.sv
// Self-checking testbench for sliding_window_median_core: directed table, then random
// sequences over many window sizes, checked against an in-bench running median predictor.
// Depends on swm_pkg and the core RTL only.
module tb_sliding_window_median_core;
  timeunit 1ns;
  timeprecision 1ps;

  import swm_pkg::*;

  // register map: index i at byte address 4*i; index 1 is not mapped
  localparam logic [APB_AW-1:0] ADDR_WSIZE    = {REG_WINDOW_SIZE, 2'b00};
  localparam logic [APB_AW-1:0] ADDR_UNMAPPED = 3'd4;

  localparam int WIN_CAP       = 64;    // WINDOW_MAX of the instance
  localparam int LATENCY       = 2;     // sample accepted -> m_tvalid
  localparam int DRAIN_CYCLES  = 4;     // settle time before a register write
  localparam int LONG_HOLD     = 300;   // one long output stall
  localparam int QUIET_LIMIT   = 4000;  // cycles with no transfer at all
  localparam int RAND_PHASES   = 14;
  localparam int PHASE_WORDS   = 105;

  localparam logic [31:0] S_MIN = 32'h8000_0000;
  localparam logic [31:0] S_MAX = 32'h7FFF_FFFF;

  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_e;

  // one directed step: a sample word, or a register write
  typedef struct packed {
    row_kind_e   kind;
    logic [2:0]  addr;
    logic [31:0] val;      // sample, or write data
    logic        last;
    logic        typed;    // expectation typed in below, else predicted
    logic        has_res;
    logic [31:0] res;
  } row_t;

  // expected median word
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] median;
    logic                       last;
  } median_exp_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [APB_AW-1:0]          paddr = '0;
  logic [APB_DW-1:0]          pwdata = '0;
  logic [APB_DW-1:0]          prdata;
  logic                       pready;
  logic                       s_tvalid = 1'b0;
  logic                       s_tready;
  logic signed [SAMPLE_W-1:0] s_tdata = '0;
  logic                       s_tlast = 1'b0;
  logic                       m_tvalid;
  logic                       m_tready = 1'b0;
  logic signed [SAMPLE_W-1:0] m_tdata;
  logic                       m_tlast;

  sliding_window_median_core #(.WINDOW_MAX(WIN_CAP)) dut (
    .clk, .rst,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .s_tvalid, .s_tready, .s_tdata, .s_tlast,
    .m_tvalid, .m_tready, .m_tdata, .m_tlast
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------
  // Predictor state: window contents in arrival order plus the register.
  // The median is taken from a sorted copy whenever the window is full.
  // ---------------------------------------------------------------------
  logic signed [SAMPLE_W-1:0] window_hist[$];
  logic [WSIZE_W-1:0]         cfg_wsize = 7'd1;   // reset value
  median_exp_t                median_q[$];        // medians still owed by the core

  int err_cnt      = 0;
  int s_gap_max    = 8;
  int r_gap_max    = 8;
  bit long_hold    = 1'b0;                        // sink takes one long stall
  int quiet_cycles = 0;

  // out-of-range sizes clamp: 0 acts as 1, above capacity acts as capacity
  function automatic int win_len(input logic [WSIZE_W-1:0] wsz);
    if (wsz == 0) return 1;
    if (wsz > WIN_CAP) return WIN_CAP;
    return int'(wsz);
  endfunction

  // Push one sample into the window; returns 1 with the lower median once
  // the window is full. End of sequence empties the window afterwards.
  function automatic bit median_step(input logic signed [SAMPLE_W-1:0] smp,
                                     input logic last,
                                     output logic signed [SAMPLE_W-1:0] med);
    logic signed [SAMPLE_W-1:0] srt[$];
    logic signed [SAMPLE_W-1:0] t;
    int n;
    int j;
    bit got;
    n   = win_len(cfg_wsize);
    got = 1'b0;
    med = '0;
    window_hist.push_back(smp);
    if (window_hist.size() > n) t = window_hist.pop_front();
    if (window_hist.size() == n) begin
      srt = window_hist;
      // insertion sort, duplicates kept
      for (int i = 1; i < n; i++) begin
        t = srt[i];
        j = i - 1;
        while (j >= 0 && srt[j] > t) begin
          srt[j+1] = srt[j];
          j--;
        end
        srt[j+1] = t;
      end
      med = srt[(n - 1) / 2];
      got = 1'b1;
    end
    if (last) window_hist.delete();
    return got;
  endfunction

  // ---------------------------------------------------------------------
  // Sample source. s_tvalid stays high across back-to-back words, so it is
  // only dropped when a gap is drawn.
  // ---------------------------------------------------------------------
  task automatic send_word(input logic [31:0] smp, input logic last,
                           input logic typed, input logic has_res,
                           input logic [31:0] res);
    int gap;
    logic signed [SAMPLE_W-1:0] med;
    bit got;
    gap = $urandom_range(0, s_gap_max);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= smp;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    // word taken at this edge: predict now, result shows no earlier than next edge
    got = median_step(smp, last, med);
    if (typed) begin
      if (has_res) median_q.push_back('{median: res, last: last});
    end else if (got) begin
      median_q.push_back('{median: med, last: last});
    end
  endtask

  // one APB transfer: setup cycle, access cycle, then the bus goes idle
  task automatic apb_access(input logic wr, input logic [APB_AW-1:0] addr,
                            input logic [APB_DW-1:0] wdata,
                            output logic [APB_DW-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Register write with the core idle, then read back window_size.
  // Samples taken while the window is still filling give nothing, so an empty
  // median queue does not mean the core is done: wait out the latency as well.
  task automatic reg_write(input logic [APB_AW-1:0] addr, input logic [31:0] val);
    logic [APB_DW-1:0] rd;
    s_tvalid <= 1'b0;
    while (median_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    apb_access(1'b1, addr, val, rd);
    if (addr == ADDR_WSIZE) begin
      cfg_wsize = val[WSIZE_W-1:0];
      window_hist.delete();
    end
    apb_access(1'b0, ADDR_WSIZE, '0, rd);
    if (rd !== {{(APB_DW-WSIZE_W){1'b0}}, cfg_wsize}) begin
      $display("%0t window_size readback: expected %0d got %0d", $time, cfg_wsize, rd);
      err_cnt++;
    end
  endtask

  // mix of full-range values, a narrow band for duplicates, and the extremes
  function automatic logic [31:0] pick_sample();
    case ($urandom_range(0, 7))
      0, 1, 2, 3: return $urandom;
      4, 5, 6:    return 32'($urandom_range(0, 8)) - 32'd4;
      default: begin
        case ($urandom_range(0, 3))
          0:       return S_MIN;
          1:       return S_MAX;
          2:       return 32'hFFFF_FFFF;
          default: return 32'd0;
        endcase
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Directed table. Window size starts at 1 after reset, so each sample is
  // its own median there; small windows below are easy to read by hand.
  // ---------------------------------------------------------------------
  localparam int DIR_ROWS = 30;
  row_t dir_tab [0:DIR_ROWS-1];

  initial begin
    dir_tab = '{
      // window of 1: extremes pass straight through
      '{ROW_SAMPLE, 3'd0,          S_MIN,         1'b0, 1'b1, 1'b1, S_MIN},
      '{ROW_SAMPLE, 3'd0,          S_MAX,         1'b0, 1'b1, 1'b1, S_MAX},
      '{ROW_SAMPLE, 3'd0,          32'd0,         1'b0, 1'b1, 1'b1, 32'd0},
      '{ROW_SAMPLE, 3'd0,          32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF},
      // write to an unmapped register is ignored
      '{ROW_WRITE,  ADDR_UNMAPPED, 32'd5,         1'b0, 1'b0, 1'b0, 32'd0},
      '{ROW_SAMPLE, 3'd0,          32'd7,         1'b0, 1'b1, 1'b1, 32'd7},
      // size 0 acts as 1
      '{ROW_WRITE,  ADDR_WSIZE,    32'd0,         1'b0, 1'b0, 1'b0, 32'd0},
      '{ROW_SAMPLE, 3'd0,          32'd123,       1'b1, 1'b1, 1'b1, 32'd123},
      // window of 3, duplicates and extremes
      '{ROW_WRITE,  ADDR_WSIZE,    32'd3,         1'b0, 1'b0, 1'b0, 32'd0},
      '{ROW_SAMPLE, 3'd0,          32'd5,         1'b0, 1'b1, 1'b0, 32'd0},
      '{ROW_SAMPLE, 3'd0,          32'hFFFF_FFFD, 1'b0, 1'b1, 1'b0, 32'd0},
      '{ROW_SAMPLE, 3'd0,          S_MAX,         1'b0, 1'b1, 1'b1, 32'd5},
      '{ROW_SAMPLE, 3'd0,          S_MIN,         1'b0, 1'b1, 1'b1, 32'hFFFF_FFFD},
      '{ROW_SAMPLE, 3'd0,          32'hFFFF_FFFD, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFD},
      // sequence ends before the window fills: nothing out, window emptied
      '{ROW_SAMPLE, 3'd0,          32'd9,         1'b1, 1'b1, 1'b0, 32'd0},
      '{ROW_SAMPLE, 3'd0,          32'd4,         1'b0, 1'b0, 1'b0, 32'd0},
      '{ROW_SAMPLE, 3'd0,          32'd4,         1'b0, 1'b0, 1'b0, 32'd0},
      '{ROW_SAMPLE, 3'd0,          32'd4,         1'b0, 1'b0, 1'b0, 32'd0},
      '{ROW_SAMPLE, 3'd0,          32'd4,         1'b1, 1'b0, 1'b0, 32'd0},
      // even window: lower median
      '{ROW_WRITE,  ADDR_WSIZE,    32'd2,         1'b0, 1'b0, 1'b0, 32'd0},
      '{ROW_SAMPLE, 3'd0,          32'd10,        1'b0, 1'b0, 1'b0, 32'd0},
      '{ROW_SAMPLE, 3'd0,          32'd20,        1'b0, 1'b1, 1'b1, 32'd10},
      '{ROW_SAMPLE, 3'd0,          32'd20,        1'b1, 1'b0, 1'b0, 32'd0},
      // bits above the register width are dropped: 0x85 -> 5
      '{ROW_WRITE,  ADDR_WSIZE,    32'h85,        1'b0, 1'b0, 1'b0, 32'd0},
      '{ROW_SAMPLE, 3'd0,          32'd3,         1'b0, 1'b0, 1'b0, 32'd0},
      '{ROW_SAMPLE, 3'd0,          32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, 32'd0},
      '{ROW_SAMPLE, 3'd0,          32'd3,         1'b0, 1'b0, 1'b0, 32'd0},
      '{ROW_SAMPLE, 3'd0,          S_MIN,         1'b0, 1'b0, 1'b0, 32'd0},
      '{ROW_SAMPLE, 3'd0,          32'd8,         1'b0, 1'b0, 1'b0, 32'd0},
      '{ROW_SAMPLE, 3'd0,          32'd3,         1'b1, 1'b0, 1'b0, 32'd0}
    };
  end

  // ---------------------------------------------------------------------
  // Median sink: random stall before each word, one long stall on request
  // so the core backs up and drops s_tready.
  // ---------------------------------------------------------------------
  initial begin
    int gap;
    median_exp_t e;
    @(negedge rst);
    forever begin
      gap = $urandom_range(0, r_gap_max);
      if (long_hold) begin
        gap = LONG_HOLD;
        long_hold = 1'b0;
      end
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      if (median_q.size() == 0) begin
        $display("%0t unexpected median word: got %0d last %0b",
                 $time, m_tdata, m_tlast);
        err_cnt++;
      end else begin
        e = median_q.pop_front();
        if (m_tdata !== e.median) begin
          $display("%0t median mismatch: expected %0d got %0d", $time, e.median, m_tdata);
          err_cnt++;
        end
        if (m_tlast !== e.last) begin
          $display("%0t tlast mismatch: expected %0b got %0b", $time, e.last, m_tlast);
          err_cnt++;
        end
      end
    end
  end

  // watchdog: any handshake or bus cycle counts as progress
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t watchdog: no progress for %0d cycles", $time, QUIET_LIMIT);
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    int wsz;
    int n;
    int seq_len;
    int eff;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_WRITE) begin
        reg_write(dir_tab[i].addr, dir_tab[i].val);
      end else begin
        send_word(dir_tab[i].val, dir_tab[i].last, dir_tab[i].typed,
                  dir_tab[i].has_res, dir_tab[i].res);
      end
    end

    // Random phases: each one sets a window size (the extremes first), then
    // runs mostly full sequences with random ends, plus some cut short.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0:       wsz = WIN_CAP;
        1:       wsz = 100;        // clamps to capacity
        2:       wsz = 1;
        3:       wsz = 127;        // largest writable value
        4:       wsz = 0;          // acts as 1
        default: wsz = ($urandom_range(0, 3) == 0) ? $urandom_range(1, WIN_CAP)
                                                   : $urandom_range(2, 9);
      endcase
      reg_write(ADDR_WSIZE, 32'(wsz));
      s_gap_max = (ph % 3 == 0) ? 0 : 8;
      r_gap_max = (ph % 4 == 1) ? 0 : 8;
      if (ph == 6) begin
        // sender flat out while the sink holds off once
        s_gap_max = 0;
        long_hold = 1'b1;
      end
      eff = win_len(cfg_wsize);
      n = 0;
      while (n < PHASE_WORDS) begin
        if ($urandom_range(0, 5) == 0) seq_len = $urandom_range(1, eff);
        else                           seq_len = eff + $urandom_range(0, 40);
        for (int k = 0; k < seq_len && n < PHASE_WORDS; k++) begin
          // the phase may end mid sequence; the next size write clears it
          send_word(pick_sample(), (k == seq_len - 1), 1'b0, 1'b0, '0);
          n++;
        end
      end
    end

    s_tvalid <= 1'b0;
    while (median_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
